>>> rtl/olv_pkg.sv
// Shared types and constants for the ordered value list unit.
package olv_pkg;

	// Default number of entries the list can hold.
	localparam int CAPACITY_DEF = 16;

	// Operation codes carried by an item.
	typedef enum logic [2:0] {
		OP_FRONT_INS  = 3'd0,
		OP_END_INS    = 3'd1,
		OP_BEFORE_INS = 3'd2,
		OP_AFTER_INS  = 3'd3,
		OP_DEL_HEAD   = 3'd4,
		OP_DEL_LAST   = 3'd5,
		OP_DEL_KEY    = 3'd6,
		OP_NONE       = 3'd7
	} op_t;

	// Status codes returned with every result.
	typedef enum logic [1:0] {
		STAT_DONE      = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_FULL      = 2'd3
	} stat_t;

	// Sequencer states.
	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_SHIFT = 1'b1
	} state_t;

	// What the cells do in the shift cycle.
	typedef enum logic [1:0] {
		MODE_HOLD   = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_DELETE = 2'd2
	} mode_t;

	// Which cell marks the position being changed.
	typedef enum logic [1:0] {
		SEL_ZERO  = 2'd0,
		SEL_COUNT = 2'd1,
		SEL_FIRST = 2'd2,
		SEL_AFTER = 2'd3
	} sel_t;

	// One command item.
	typedef struct packed {
		logic [2:0]         operation;
		logic signed [31:0] key;
		logic signed [31:0] value;
	} olv_in_t;

	// One result item.
	typedef struct packed {
		stat_t      status;
		logic [4:0] entry_count;
	} olv_out_t;

	// Control broadcast from the sequencer to every cell.
	typedef struct packed {
		logic               cmp_en;
		mode_t              mode;
		sel_t               sel;
		logic signed [31:0] key;
		logic signed [31:0] value;
	} cell_bus_t;

	// Flags handed from each cell to its right-hand neighbor.
	typedef struct packed {
		logic seen;
		logic first;
		logic past;
	} cell_link_t;

endpackage

>>> rtl/olv_cell.sv
// One cell of the list: holds one entry and its registered key match.
module olv_cell #(
	parameter int CAPACITY = olv_pkg::CAPACITY_DEF,
	parameter int INDEX    = 0,
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input  logic                clk,
	input  olv_pkg::cell_bus_t  bus,
	input  logic [CW-1:0]       count,
	input  olv_pkg::cell_link_t lnk_i,
	output olv_pkg::cell_link_t lnk_o,
	input  logic signed [31:0]  left_data,
	input  logic signed [31:0]  right_data,
	output logic signed [31:0]  data
);
	import olv_pkg::*;

	logic signed [31:0] data_q;
	logic               match_q;
	logic               valid;
	logic               cand;
	logic               first;
	logic               at;

	// The cell holds a live entry when its index is below the count.
	assign valid = (CW'(INDEX) < count);
	assign cand  = match_q & valid;
	assign first = cand & ~lnk_i.seen;

	// Decide whether this cell is the position being changed.
	always_comb begin
		case (bus.sel)
			SEL_ZERO:  at = (INDEX == 0);
			SEL_COUNT: at = (CW'(INDEX) == count);
			SEL_FIRST: at = first;
			SEL_AFTER: at = lnk_i.first;
			default:   at = 1'b0;
		endcase
	end

	// Pass the search and position flags on to the right.
	assign lnk_o.seen  = lnk_i.seen | cand;
	assign lnk_o.first = first;
	assign lnk_o.past  = lnk_i.past | at;

	// Compare against the key in the accept cycle.
	always_ff @(posedge clk) begin
		if (bus.cmp_en) begin
			match_q <= (data_q == bus.key);
		end
	end

	// Shift or load the entry in the shift cycle.
	always_ff @(posedge clk) begin
		case (bus.mode)
			MODE_INSERT: begin
				if (at) begin
					data_q <= bus.value;
				end else if (lnk_i.past) begin
					data_q <= left_data;
				end
			end
			MODE_DELETE: begin
				if (at || lnk_i.past) begin
					data_q <= right_data;
				end
			end
			default: begin
			end
		endcase
	end

	assign data = data_q;

endmodule

>>> rtl/ordered_value_list_unit.sv
// Top level of the ordered value list unit: sequencer and row of list cells.
//
// Holds an ordered list of up to CAPACITY signed 32-bit values. An item is
// taken when start is high and busy is low. In that cycle every cell compares
// its entry with the key; in the next cycle (busy high) a priority chain through
// the cells finds the first match and, where the operation moves entries, the
// cells shift left or right by one place. The result, status and entry count
// after the operation, appears on result for exactly one cycle with done high,
// in the cycle after busy; the next item may be started in that same cycle, but
// no new item is taken while the cell row shifts for the one before it.
// The receiver cannot hold results off. entry_count reports the count modulo 32.
module ordered_value_list_unit #(
	parameter int CAPACITY = olv_pkg::CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  olv_pkg::olv_in_t  cmd,
	output logic              done,
	output olv_pkg::olv_out_t result
);
	import olv_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	state_t             state_q;
	state_t             state_d;
	op_t                op_q;
	logic signed [31:0] value_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_d;
	logic               accept;
	logic               found;
	stat_t              status;
	mode_t              mode;
	sel_t               sel;
	cell_bus_t          bus;
	logic               done_q;
	olv_out_t           result_q;

	cell_link_t         lnk [CAPACITY+1];
	logic signed [31:0] cell_data [CAPACITY];

	assign accept = start && (state_q == ST_IDLE);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, status and the cell commands for the shift cycle.
	always_comb begin
		state_d = state_q;
		status  = STAT_DONE;
		mode    = MODE_HOLD;
		sel     = SEL_ZERO;
		count_d = count_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				state_d = ST_IDLE;
				case (op_q)
					OP_FRONT_INS, OP_END_INS, OP_BEFORE_INS, OP_AFTER_INS: begin
						if (count_q == CW'(CAPACITY)) begin
							status = STAT_FULL;
						end else if (op_q == OP_FRONT_INS) begin
							sel = SEL_ZERO;
						end else if (op_q == OP_END_INS) begin
							sel = SEL_COUNT;
						end else if (count_q == '0) begin
							status = STAT_EMPTY;
						end else if (!found) begin
							status = STAT_NOT_FOUND;
						end else begin
							sel = (op_q == OP_BEFORE_INS) ? SEL_FIRST : SEL_AFTER;
						end
						if (status == STAT_DONE) begin
							mode    = MODE_INSERT;
							count_d = count_q + 1'b1;
						end
					end
					OP_DEL_HEAD, OP_DEL_LAST: begin
						if (count_q == '0) begin
							status = STAT_EMPTY;
						end else begin
							count_d = count_q - 1'b1;
							if (op_q == OP_DEL_HEAD) begin
								mode = MODE_DELETE;
								sel  = SEL_ZERO;
							end
						end
					end
					OP_DEL_KEY: begin
						if (count_q == '0) begin
							status = STAT_EMPTY;
						end else if (!found) begin
							status = STAT_NOT_FOUND;
						end else begin
							mode    = MODE_DELETE;
							sel     = SEL_FIRST;
							count_d = count_q - 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Item registers captured at accept.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op_t'(cmd.operation);
			value_q <= cmd.value;
		end
	end

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	// Result strobe and payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_SHIFT);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SHIFT) begin
			result_q.status      <= status;
			result_q.entry_count <= 5'(count_d);
		end
	end

	// Broadcast to the cells.
	assign bus.cmp_en = accept;
	assign bus.mode   = mode;
	assign bus.sel    = sel;
	assign bus.key    = cmd.key;
	assign bus.value  = value_q;

	// Row of cells, head at index zero.
	assign lnk[0] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] left_w;
		logic signed [31:0] right_w;

		if (i == 0) begin : g_head
			assign left_w = '0;
		end else begin : g_body
			assign left_w = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_w = cell_data[i];
		end else begin : g_mid
			assign right_w = cell_data[i+1];
		end

		olv_cell #(
			.CAPACITY (CAPACITY),
			.INDEX    (i),
			.CW       (CW)
		) u_cell (
			.clk        (clk),
			.bus        (bus),
			.count      (count_q),
			.lnk_i      (lnk[i]),
			.lnk_o      (lnk[i+1]),
			.left_data  (left_w),
			.right_data (right_w),
			.data       (cell_data[i])
		);
	end

	assign found  = lnk[CAPACITY].seen;
	assign busy   = (state_q == ST_SHIFT);
	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	// Every shift cycle produces exactly one result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |=> done)
		else $error("result strobe missing after shift cycle");

	// The count never exceeds the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// A full status only happens on a full list and leaves it full.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == STAT_FULL) |-> (count_q == CW'(CAPACITY)))
		else $error("full status reported on a list that is not full");

	// A result never shows in the same cycle as busy.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe during busy");
`endif

endmodule
